// ===== hw/rtl/nlt_pkg.sv =====
// Shared constants, types and helpers of the neighborhood lock table.
package nlt_pkg;

   localparam int CAPACITY = 16;
   localparam int RADIUS   = 1;

   localparam int COORD_W  = 32;
   localparam int STATUS_W = 3;
   localparam int HELD_W   = 5;
   localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int SCAN_W   = $clog2(CAPACITY + 1);
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int PADDR_W  = 3;
   localparam int PDATA_W  = 32;

   localparam logic signed [COORD_W:0] REACH = (COORD_W + 1)'(2 * RADIUS);

   localparam logic [PADDR_W-1:0] ADDR_LOCK_ENABLE = PADDR_W'(0);
   localparam logic               LOCK_ENABLE_RESET = 1'b1;

   typedef enum logic {
      OP_LOCK    = 1'b0,
      OP_RELEASE = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_GRANTED  = 3'd0,
      ST_CONFLICT = 3'd1,
      ST_FULL     = 3'd2,
      ST_RELEASED = 3'd3,
      ST_NOT_HELD = 3'd4
   } status_type;

   typedef struct packed {
      logic near;   // both axes within twice the radius
      logic same;   // both axes equal
   } cmp_result_type;

   function automatic logic [HELD_W-1:0] held_field(input logic [COUNT_W-1:0] count);
      logic [COUNT_W+HELD_W-1:0] wide;
      wide = (COUNT_W + HELD_W)'(count);
      return wide[HELD_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/nlt_if.sv =====
// Request and response channel interfaces of the neighborhood lock table.
interface nlt_req_if
   import nlt_pkg::*;
   ();
   logic                       valid;
   logic                       ready;
   logic                       operation;
   logic signed [COORD_W-1:0]  pos_x;
   logic signed [COORD_W-1:0]  pos_z;

   modport source (output valid, operation, pos_x, pos_z, input ready);
   modport sink   (input valid, operation, pos_x, pos_z, output ready);
endinterface

interface nlt_rsp_if
   import nlt_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [HELD_W-1:0]    held_count;

   modport source (output valid, status, held_count, input ready);
   modport sink   (input valid, status, held_count, output ready);
endinterface

// ===== hw/rtl/nlt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module nlt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hw/rtl/nlt_compare.sv =====
// Shared coordinate compare unit: overlap and exact-match test of two centers.
module nlt_compare
   import nlt_pkg::*;
(
   input  logic signed [COORD_W-1:0] held_x,
   input  logic signed [COORD_W-1:0] held_z,
   input  logic signed [COORD_W-1:0] pos_x,
   input  logic signed [COORD_W-1:0] pos_z,
   output cmp_result_type            result
);
   logic signed [COORD_W:0] diff_x;
   logic signed [COORD_W:0] diff_z;
   logic                    near_x;
   logic                    near_z;

   // widen by one bit so the difference never wraps
   assign diff_x = {held_x[COORD_W-1], held_x} - {pos_x[COORD_W-1], pos_x};
   assign diff_z = {held_z[COORD_W-1], held_z} - {pos_z[COORD_W-1], pos_z};

   assign near_x = (diff_x <= REACH) && (diff_x >= -REACH);
   assign near_z = (diff_z <= REACH) && (diff_z >= -REACH);

   assign result.near = near_x && near_z;
   assign result.same = (diff_x == '0) && (diff_z == '0);
endmodule

// ===== hw/rtl/neighborhood_lock_table.sv =====
// Neighborhood lock table: top level with scan sequencer, slot store and APB port.
//
// Usage:
//   req_ch carries one request: operation (lock or release) and a signed
//   (pos_x, pos_z) center. rsp_ch returns one response per request: status
//   and the number of held regions after the request.
//   csr_* is an APB port with one register, lock_enable, at address 0.
// Sequencing:
//   A request with locking enabled scans all CAPACITY slots, one per cycle
//   through the single slot RAM read port and one compare unit, then goes
//   to S_UPDATE, which registers the response once the output register is
//   free, and returns to S_IDLE before the next request is taken. With
//   locking disabled the request skips S_SCAN and goes straight to S_UPDATE.
//   req_ch.ready is high only while no request is in progress.
// Reset:
//   Synchronous, active high. All slots become free, lock_enable returns
//   to 1. No clearing pass is needed.
// Stall:
//   A response waits in the output register; a finished scan holds its
//   update until that register is free.
module neighborhood_lock_table
   import nlt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   nlt_req_if.sink             req_ch,
   nlt_rsp_if.source           rsp_ch,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [PADDR_W-1:0]  csr_paddr,
   input  logic [PDATA_W-1:0]  csr_pwdata,
   output logic [PDATA_W-1:0]  csr_prdata,
   output logic                csr_pready
);
   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_UPDATE
   } state_type;

   state_type                  state_ff, state_in;
   logic                       lock_enable_ff, lock_enable_in;
   logic                       op_ff;
   logic signed [COORD_W-1:0]  pos_x_ff;
   logic signed [COORD_W-1:0]  pos_z_ff;
   logic [CAPACITY-1:0]        valid_ff, valid_in;
   logic [COUNT_W-1:0]         count_ff, count_in;
   logic [SCAN_W-1:0]          scan_idx_ff, scan_idx_in;
   logic [SLOT_W-1:0]          cmp_idx_ff, cmp_idx_in;
   logic                       cmp_live_ff, cmp_live_in;
   logic                       clash_ff, clash_in;
   logic                       free_found_ff, free_found_in;
   logic [SLOT_W-1:0]          free_slot_ff, free_slot_in;
   logic                       match_found_ff, match_found_in;
   logic [SLOT_W-1:0]          match_slot_ff, match_slot_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   status_type                 rsp_status_ff, rsp_status_in;
   logic [HELD_W-1:0]          rsp_held_ff, rsp_held_in;

   logic                       req_fire;
   logic                       out_free;
   logic                       csr_write;
   logic [SLOT_W-1:0]          scan_slot;
   logic                       ram_wr_en;
   logic [2*COORD_W-1:0]       ram_rd_data;
   cmp_result_type             cmp_result;

   assign req_fire  = req_ch.valid && req_ch.ready;
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign scan_slot = scan_idx_ff[SLOT_W-1:0];
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                      (csr_paddr == ADDR_LOCK_ENABLE);

   nlt_ram #(
      .WIDTH (2 * COORD_W),
      .DEPTH (CAPACITY)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (free_slot_ff),
      .wr_data ({pos_x_ff, pos_z_ff}),
      .rd_addr (scan_slot),
      .rd_data (ram_rd_data)
   );

   nlt_compare u_compare (
      .held_x (ram_rd_data[2*COORD_W-1:COORD_W]),
      .held_z (ram_rd_data[COORD_W-1:0]),
      .pos_x  (pos_x_ff),
      .pos_z  (pos_z_ff),
      .result (cmp_result)
   );

   always_comb begin
      state_in       = state_ff;
      lock_enable_in = csr_write ? csr_pwdata[0] : lock_enable_ff;
      valid_in       = valid_ff;
      count_in       = count_ff;
      scan_idx_in    = scan_idx_ff;
      cmp_idx_in     = cmp_idx_ff;
      cmp_live_in    = 1'b0;
      clash_in       = clash_ff;
      free_found_in  = free_found_ff;
      free_slot_in   = free_slot_ff;
      match_found_in = match_found_ff;
      match_slot_in  = match_slot_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_held_in    = rsp_held_ff;
      ram_wr_en      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               scan_idx_in    = '0;
               clash_in       = 1'b0;
               free_found_in  = 1'b0;
               match_found_in = 1'b0;
               state_in       = lock_enable_ff ? S_SCAN : S_UPDATE;
            end
         end
         S_SCAN: begin
            // issue one slot read per cycle; compare the slot read last cycle
            if (scan_idx_ff < SCAN_W'(CAPACITY)) begin
               cmp_live_in = 1'b1;
               cmp_idx_in  = scan_slot;
               scan_idx_in = scan_idx_ff + SCAN_W'(1);
               if (!valid_ff[scan_slot] && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_slot_in  = scan_slot;
               end
            end else begin
               state_in = S_UPDATE;
            end
            if (cmp_live_ff && valid_ff[cmp_idx_ff]) begin
               if (cmp_result.near) begin
                  clash_in = 1'b1;
               end
               if (cmp_result.same && !match_found_ff) begin
                  match_found_in = 1'b1;
                  match_slot_in  = cmp_idx_ff;
               end
            end
         end
         S_UPDATE: begin
            if (out_free) begin
               if (!lock_enable_ff) begin
                  rsp_status_in = (op_ff == OP_RELEASE) ? ST_RELEASED : ST_GRANTED;
               end else if (op_ff == OP_LOCK) begin
                  if (clash_ff) begin
                     rsp_status_in = ST_CONFLICT;
                  end else if (!free_found_ff) begin
                     rsp_status_in = ST_FULL;
                  end else begin
                     rsp_status_in          = ST_GRANTED;
                     ram_wr_en              = 1'b1;
                     valid_in[free_slot_ff] = 1'b1;
                     count_in               = count_ff + COUNT_W'(1);
                  end
               end else begin
                  if (match_found_ff) begin
                     rsp_status_in           = ST_RELEASED;
                     valid_in[match_slot_ff] = 1'b0;
                     count_in                = count_ff - COUNT_W'(1);
                  end else begin
                     rsp_status_in = ST_NOT_HELD;
                  end
               end
               rsp_held_in  = held_field(count_in);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         lock_enable_ff <= LOCK_ENABLE_RESET;
         valid_ff       <= '0;
         count_ff       <= '0;
         cmp_live_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         lock_enable_ff <= lock_enable_in;
         valid_ff       <= valid_in;
         count_ff       <= count_in;
         cmp_live_ff    <= cmp_live_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      scan_idx_ff    <= scan_idx_in;
      cmp_idx_ff     <= cmp_idx_in;
      clash_ff       <= clash_in;
      free_found_ff  <= free_found_in;
      free_slot_ff   <= free_slot_in;
      match_found_ff <= match_found_in;
      match_slot_ff  <= match_slot_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_held_ff    <= rsp_held_in;
      if (req_fire) begin
         op_ff    <= req_ch.operation;
         pos_x_ff <= req_ch.pos_x;
         pos_z_ff <= req_ch.pos_z;
      end
   end

   assign req_ch.ready      = (state_ff == S_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.held_count = rsp_held_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == ADDR_LOCK_ENABLE) ? PDATA_W'(lock_enable_ff) : '0;

`ifndef SYNTHESIS
   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      count_ff == COUNT_W'($countones(valid_ff)))
      else $error("held count differs from number of valid slots");

   a_release_clears_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPDATE && out_free && lock_enable_ff && op_ff == OP_RELEASE &&
       match_found_ff) |=> !valid_ff[$past(match_slot_ff)])
      else $error("released slot still valid");

   a_full_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_FULL) |-> count_ff == COUNT_W'(CAPACITY))
      else $error("table full reported with a free slot");
`endif
endmodule
